[rtl/srrip_pkg.sv]
// types, constants and signature-table lookup for the rrip replacement engine
// no dependencies
package srrip_pkg;

    localparam int SETS        = 2048;
    localparam int WAYS        = 16;
    localparam int SIG_SLOTS   = 8;
    localparam int SIG_WIDTH   = 6;
    localparam int SET_W       = 11;
    localparam int WAY_W       = 4;
    localparam int SLOT_W      = 3;
    localparam int PC_W        = 9;
    localparam int ADDR_W      = 64;
    localparam int MASK_W      = 16;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 8;

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef logic [1:0]           t_ctr;
    typedef logic [SIG_WIDTH-1:0] t_sig;

    localparam t_ctr RRPV_MAX     = 2'd3;
    localparam t_ctr CTR_MAX      = 2'd3;
    localparam t_ctr REUSE_STRONG = 2'd2;
    localparam t_ctr REUSE_WEAK   = 2'd1;

    localparam logic [ADDR_W-1:0] STRIDE_POS = 64'd64;
    localparam logic [ADDR_W-1:0] STRIDE_NEG = 64'hFFFF_FFFF_FFFF_FFC0;

    typedef struct packed {
        t_ctr [WAYS-1:0] rrpv;
        t_sig [WAYS-1:0] sig;
    } t_way_row;

    typedef struct packed {
        t_sig [SIG_SLOTS-1:0] tag;
        t_ctr [SIG_SLOTS-1:0] reuse;
        logic [SIG_SLOTS-1:0] refilled;
        t_ctr                 stride;
        logic [ADDR_W-1:0]    prev;
    } t_set_row;

    typedef struct packed {
        t_set_row          row;
        logic [SLOT_W-1:0] slot;
    } t_find;

    function automatic t_sig make_sig(logic [PC_W-1:0] pc);
        return t_sig'(pc ^ (pc >> 3));
    endfunction

    function automatic t_find find_slot(t_set_row r, t_sig s);
        t_find f;
        logic  found;
        logic  free;
        f.row = r;
        f.slot = '0;
        found = 1'b0;
        free = 1'b0;
        for (int i = SIG_SLOTS - 1; i >= 0; i--) begin
            if (r.tag[i] == s) begin
                found = 1'b1;
                f.slot = SLOT_W'(i);
            end
        end
        if (!found) begin
            for (int i = SIG_SLOTS - 1; i >= 0; i--) begin
                if (!r.refilled[i]) begin
                    free = 1'b1;
                    f.slot = SLOT_W'(i);
                end
            end
            if (!free) begin
                f.row.refilled = '0;
                f.slot = '0;
            end
            f.row.tag[f.slot] = s;
            f.row.reuse[f.slot] = REUSE_WEAK;
            f.row.refilled[f.slot] = 1'b1;
        end
        return f;
    endfunction

endpackage

[rtl/srrip_victim.sv]
// victim selection: first invalid way, else age the set row and pick first distant way
// depends on srrip_pkg
module srrip_victim (
    input  srrip_pkg::t_way_row             i_row,
    input  logic [srrip_pkg::MASK_W-1:0]    i_mask,
    output srrip_pkg::t_way_row             o_row,
    output logic                            o_aged,
    output logic [srrip_pkg::WAY_W-1:0]     o_way
);
    import srrip_pkg::*;

    logic                 inv_found;
    logic [WAY_W-1:0]     inv_way;
    logic [WAY_W-1:0]     far_way;
    logic [WAYS-1:0]      is3, is2, is1;
    t_ctr                 top;
    t_ctr                 age;

    always_comb begin
        inv_found = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (!i_mask[w]) begin
                inv_found = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            is3[w] = i_row.rrpv[w] == 2'd3;
            is2[w] = i_row.rrpv[w] == 2'd2;
            is1[w] = i_row.rrpv[w] == 2'd1;
        end
        priority if (|is3) top = 2'd3;
        else if (|is2) top = 2'd2;
        else if (|is1) top = 2'd1;
        else top = 2'd0;
        age = RRPV_MAX - top;
        o_row = i_row;
        for (int w = 0; w < WAYS; w++) begin
            o_row.rrpv[w] = i_row.rrpv[w] + age;
        end
        far_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (o_row.rrpv[w] == RRPV_MAX) begin
                far_way = WAY_W'(w);
            end
        end
        o_aged = !inv_found;
        o_way = inv_found ? inv_way : far_way;
    end

endmodule

[rtl/signature_reuse_rrip_replacement.sv]
// top level of the signature-based rrip replacement engine: set memories and sequencer
// depends on srrip_pkg and srrip_victim
//
//  port group   dir  width  contents
//  i_s_*        in   112    request: set, way, hit, pc, address, valid mask; tuser = operation
//  o_m_*        out  8      victim way
//
//  a victim request runs the memory read and a lookup; an update runs memory read, lookup, second lookup and write
//  the set memories give one read-modify-write per request, which sets the rate
//  after reset a clearing pass over all 2048 sets runs before the first request is taken
//  a stalled output holds the next request back once the engine is idle
module signature_reuse_rrip_replacement (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // set_index, way_index, hit, pc_bits, line_address, valid_mask, zero fill
    input  logic [srrip_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // operation
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // victim_way, zero fill
    output logic [srrip_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import srrip_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EX1  = 3'd2;
    localparam logic [2:0] S_EX2  = 3'd3;

    t_way_row r_way_mem [SETS];
    t_set_row r_set_mem [SETS];

    logic [2:0]         r_state, n_state;
    logic [SET_W-1:0]   r_clr_cnt;
    logic               r_op;
    logic [SET_W-1:0]   r_set;
    logic [WAY_W-1:0]   r_way;
    logic               r_hit;
    logic [PC_W-1:0]    r_pc;
    logic [ADDR_W-1:0]  r_addr;
    logic [MASK_W-1:0]  r_mask;
    t_way_row           r_way_rd;
    t_set_row           r_set_rd;
    t_way_row           r_way_row;
    t_set_row           r_set_row;
    t_sig               r_old_sig;
    t_ctr               r_old_rrpv;
    logic               r_m_valid;
    logic [WAY_W-1:0]   r_m_way;

    logic               accept;
    t_way_row           vic_row;
    logic               vic_aged;
    logic [WAY_W-1:0]   vic_way;
    logic [ADDR_W-1:0]  delta;
    logic               stride;
    t_set_row           s1;
    t_find              f1;
    t_find              f2;
    t_sig               sig;
    t_way_row           upd_way;
    t_set_row           upd_set;
    t_set_row           fin_set;
    logic               way_we;
    logic               set_we;
    logic [SET_W-1:0]   wr_set;
    t_way_row           way_wd;
    t_set_row           set_wd;
    t_way_row           way_clr;
    t_set_row           set_clr;

    assign o_s_tready = (r_state == S_IDLE) && (!r_m_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_m_way);

    srrip_victim u_victim (
        .i_row  (r_way_rd),
        .i_mask (r_mask),
        .o_row  (vic_row),
        .o_aged (vic_aged),
        .o_way  (vic_way)
    );

    always_comb begin
        delta = (r_set_rd.prev != '0) ? r_addr - r_set_rd.prev : '0;
        stride = (delta == STRIDE_POS) || (delta == STRIDE_NEG);
        s1 = r_set_rd;
        s1.prev = r_addr;
        if (stride) begin
            if (r_set_rd.stride < CTR_MAX) s1.stride = r_set_rd.stride + 2'd1;
        end else if (r_set_rd.stride > 2'd0) begin
            s1.stride = r_set_rd.stride - 2'd1;
        end
        sig = make_sig(r_pc);
        f1 = find_slot(s1, sig);
        upd_set = f1.row;
        upd_way = r_way_rd;
        if (r_hit) begin
            if (f1.row.reuse[f1.slot] < CTR_MAX) begin
                upd_set.reuse[f1.slot] = f1.row.reuse[f1.slot] + 2'd1;
            end
            upd_way.rrpv[r_way] = 2'd0;
        end else begin
            upd_way.sig[r_way] = sig;
            if (s1.stride == CTR_MAX) upd_way.rrpv[r_way] = RRPV_MAX;
            else upd_way.rrpv[r_way] =
                (f1.row.reuse[f1.slot] >= REUSE_STRONG) ? 2'd0 : RRPV_MAX;
        end
    end

    always_comb begin
        f2 = find_slot(r_set_row, r_old_sig);
        fin_set = r_set_row;
        if (!r_hit) begin
            fin_set = f2.row;
            if (r_old_rrpv == RRPV_MAX && f2.row.reuse[f2.slot] > 2'd0) begin
                fin_set.reuse[f2.slot] = f2.row.reuse[f2.slot] - 2'd1;
            end
        end
    end

    always_comb begin
        way_clr = '0;
        for (int w = 0; w < WAYS; w++) way_clr.rrpv[w] = RRPV_MAX;
        set_clr = '0;
        way_we = 1'b0;
        set_we = 1'b0;
        wr_set = r_set;
        way_wd = r_way_row;
        set_wd = fin_set;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                way_we = 1'b1;
                set_we = 1'b1;
                wr_set = r_clr_cnt;
                way_wd = way_clr;
                set_wd = set_clr;
                if (r_clr_cnt == SET_W'(SETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_EX1;
            end
            S_EX1: begin
                if (r_op == OP_VICTIM) begin
                    way_we = vic_aged;
                    way_wd = vic_row;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EX2;
                end
            end
            S_EX2: begin
                way_we = 1'b1;
                set_we = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (way_we) r_way_mem[wr_set] <= way_wd;
        if (set_we) r_set_mem[wr_set] <= set_wd;
        if (accept) begin
            r_way_rd <= r_way_mem[i_s_tdata[10:0]];
            r_set_rd <= r_set_mem[i_s_tdata[10:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_s_tuser;
            r_set  <= i_s_tdata[10:0];
            r_way  <= i_s_tdata[14:11];
            r_hit  <= i_s_tdata[15];
            r_pc   <= i_s_tdata[24:16];
            r_addr <= i_s_tdata[88:25];
            r_mask <= i_s_tdata[104:89];
        end
        if (r_state == S_EX1) begin
            r_way_row  <= upd_way;
            r_set_row  <= upd_set;
            r_old_sig  <= r_way_rd.sig[r_way];
            r_old_rrpv <= r_way_rd.rrpv[r_way];
            r_m_way    <= vic_way;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr_cnt <= r_clr_cnt + SET_W'(1);
            if (r_state == S_EX1 && r_op == OP_VICTIM) r_m_valid <= 1'b1;
            else if (i_m_tready) r_m_valid <= 1'b0;
        end
    end

    a_out_from_ex1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state) == S_EX1 && $past(r_op) == OP_VICTIM)
        else $error("victim result without a victim request");

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> !o_s_tready)
        else $error("request taken during clearing pass");

    a_ex2_after_ex1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EX2 |-> $past(r_state) == S_EX1 && r_op != OP_VICTIM)
        else $error("write-back stage entered out of order");

    a_out_free_for_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EX1 && r_op == OP_VICTIM |-> !r_m_valid)
        else $error("victim result would overwrite pending result");

endmodule

[tb/tb.sv]
// testbench for signature_reuse_rrip_replacement: random and directed requests, victim checks
// depends on srrip_pkg and the rtl; holds its own predictor of rrpv, signature and stride state
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srrip_pkg::*;

    localparam int LIMIT = 2000000;

    class victim_board;
        logic [1:0]  rrpv [SETS*WAYS];
        logic [5:0]  lsig [SETS*WAYS];
        logic [5:0]  tag [SETS*SIG_SLOTS];
        logic [1:0]  reuse [SETS*SIG_SLOTS];
        logic        refl [SETS*SIG_SLOTS];
        logic [1:0]  stride [SETS];
        logic [63:0] prev [SETS];
        logic [3:0]  victims [$];
        int          errors;

        function void clear();
            foreach (rrpv[i]) begin
                rrpv[i] = 2'd3;
                lsig[i] = '0;
            end
            foreach (tag[i]) begin
                tag[i] = '0;
                reuse[i] = '0;
                refl[i] = 1'b0;
            end
            foreach (stride[i]) begin
                stride[i] = '0;
                prev[i] = '0;
            end
            errors = 0;
        endfunction

        function int lookup(int set, logic [5:0] s);
            int b;
            int i;
            b = set * SIG_SLOTS;
            for (i = 0; i < SIG_SLOTS; i++)
                if (tag[b+i] == s) return b + i;
            for (i = 0; i < SIG_SLOTS; i++)
                if (!refl[b+i]) break;
            if (i == SIG_SLOTS) begin
                for (int k = 0; k < SIG_SLOTS; k++) refl[b+k] = 1'b0;
                i = 0;
            end
            tag[b+i] = s;
            reuse[b+i] = 2'd1;
            refl[b+i] = 1'b1;
            return b + i;
        endfunction

        function void note(logic op, logic [111:0] d);
            logic [10:0] set;
            logic [3:0]  way;
            logic        hit;
            logic [8:0]  pc;
            logic [63:0] addr, delta;
            logic [15:0] mask;
            logic [5:0]  s, osig;
            logic [1:0]  orr, top;
            int          b, row, sl, vs, w;
            {mask, addr, pc, hit, way, set} = d[104:0];
            b = set * WAYS;
            if (op == OP_VICTIM) begin
                for (w = 0; w < WAYS; w++)
                    if (!mask[w]) break;
                if (w < WAYS) begin
                    victims.push_back(4'(w));
                    return;
                end
                top = 0;
                for (w = 0; w < WAYS; w++)
                    if (rrpv[b+w] > top) top = rrpv[b+w];
                for (w = 0; w < WAYS; w++) rrpv[b+w] = rrpv[b+w] + (2'd3 - top);
                for (w = 0; w < WAYS; w++)
                    if (rrpv[b+w] == 2'd3) break;
                victims.push_back(w < WAYS ? 4'(w) : 4'd0);
                return;
            end
            row = b + way;
            osig = lsig[row];
            orr = rrpv[row];
            delta = (prev[set] != 0) ? addr - prev[set] : 64'd0;
            prev[set] = addr;
            if (delta == 64'd64 || delta == -64'sd64) begin
                if (stride[set] < 3) stride[set]++;
            end else if (stride[set] > 0) begin
                stride[set]--;
            end
            s = 6'(pc ^ (pc >> 3));
            sl = lookup(set, s);
            if (hit) begin
                if (reuse[sl] < 3) reuse[sl]++;
                rrpv[row] = 0;
            end else begin
                lsig[row] = s;
                rrpv[row] = (stride[set] == 3) ? 2'd3 : (reuse[sl] >= 2 ? 2'd0 : 2'd3);
                vs = lookup(set, osig);
                if (orr == 2'd3 && reuse[vs] > 0) reuse[vs]--;
            end
        endfunction

        function void check(logic [7:0] got);
            logic [3:0] want;
            if (victims.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected victim %0d", got);
                return;
            end
            want = victims.pop_front();
            if (got !== {4'd0, want}) begin
                errors++;
                if (errors <= 10) $display("victim mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [111:0] i_s_tdata = '0;
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [7:0]   o_m_tdata;
    victim_board  board;
    int           cycles = 0;
    logic         sending = 1'b1;

    signature_reuse_rrip_replacement i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL signature_reuse_rrip_replacement");
            $finish;
        end
    end

    function automatic int gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check(o_m_tdata);
        i_m_tready <= ($urandom_range(0, 3) != 0) || !sending;
    end

    task automatic send(logic op, logic [10:0] set, logic [3:0] way, logic hit,
                        logic [8:0] pc, logic [63:0] addr, logic [15:0] mask, int idle);
        repeat (idle + 1) @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {7'd0, mask, addr, pc, hit, way, set};
        do @(posedge i_clk); while (!o_s_tready);
        board.note(op, {7'd0, mask, addr, pc, hit, way, set});
        i_s_tvalid <= 1'b0;
    endtask

    task automatic rnd_item(int idle);
        logic [10:0] set;
        logic [63:0] addr;
        logic [15:0] mask;
        set = $urandom_range(0, 3) == 0 ? 11'($urandom) : 11'($urandom_range(0, 3));
        addr = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'($urandom_range(0, 15)) << 6;
        mask = $urandom_range(0, 2) ? 16'hffff : 16'($urandom);
        send(($urandom_range(0, 2) == 0) ? OP_UPDATE : OP_VICTIM, set, 4'($urandom),
             1'($urandom),
             $urandom_range(0, 3) ? 9'($urandom_range(0, 15)) : 9'($urandom), addr, mask, idle);
    endtask

    initial begin
        board = new();
        board.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send(OP_VICTIM, 0, 0, 0, 0, 0, 16'hffff, 0);
        send(OP_VICTIM, 11'd2047, 15, 1, 9'd511, '1, 16'h7fff, 0);
        send(OP_VICTIM, 5, 0, 0, 0, 0, 16'hfffe, 0);
        send(OP_UPDATE, 5, 3, 0, 9'd0, 64'h1000, 0, 0);
        send(OP_UPDATE, 5, 3, 0, 9'd0, 64'h1040, 0, 0);
        send(OP_UPDATE, 5, 4, 0, 9'd1, 64'h1000, 0, 0);
        send(OP_UPDATE, 5, 5, 1, 9'd1, 64'h1040, 0, 1);
        send(OP_UPDATE, 5, 5, 1, 9'd1, 64'h1080, 0, 0);
        send(OP_UPDATE, 5, 6, 0, 9'd1, 64'h10c0, 0, 0);
        send(OP_UPDATE, 5, 7, 0, 9'd2, '1, 16'hffff, 0);
        send(OP_UPDATE, 11'd2047, 15, 1, 9'd511, 64'h8000_0000_0000_0000, 16'h0, 0);
        for (int p = 0; p < 10; p++)
            send(OP_UPDATE, 5, 4'(p), 0, 9'(p * 8), 64'(p * 999), 0, 0);
        send(OP_VICTIM, 5, 0, 0, 0, 0, 16'hffff, 0);
        send(OP_VICTIM, 5, 0, 0, 0, 0, 16'hffff, 0);
        for (int n = 0; n < 1050; n++) begin
            if (n == 500) begin
                sending = 1'b0;
                while (board.victims.size() != 0) @(posedge i_clk);
                sending = 1'b1;
            end
            rnd_item((n % 200 < 20) ? 0 : gap());
        end
        sending = 1'b0;
        while (board.victims.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("PASS signature_reuse_rrip_replacement");
        end else begin
            $display("FAIL signature_reuse_rrip_replacement");
        end
        $finish;
    end
endmodule
